### rtl/core/pedec_pkg.sv
// ----------------------------------------------------------------------------
// pedec_pkg
// shared types, constants and helper functions of the percent escape decoder
// ----------------------------------------------------------------------------
package pedec_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // decoded bytes released by one input item, oldest in b0
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    logic       last;
  } group_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    hex_nibble = v[3:0];
  endfunction

endpackage

### rtl/core/pedec_front.sv
// ----------------------------------------------------------------------------
// pedec_front
// classifies each input item and builds the group of bytes it releases
// ----------------------------------------------------------------------------
module pedec_front import pedec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       grp_valid,
  output group_t     grp
);

  phase_t     phase, phase_next;
  logic [7:0] held_digit, held_digit_next;

  logic [7:0]      c;
  logic            c_hex;
  logic [2:0][7:0] bytes;
  logic [1:0]      n;
  logic            tail;

  always_comb begin
    c               = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    c_hex           = is_hex(c);
    bytes           = '0;
    n               = 2'd0;
    tail            = 1'b0;
    phase_next      = PH_IDLE;
    held_digit_next = 8'h00;

    case (phase)
      PH_PCT: begin
        if (c_hex) begin
          phase_next      = PH_DIGIT;
          held_digit_next = c;
        end else begin
          bytes[n] = CH_PERCENT;
          n        = n + 2'd1;
          tail     = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (c_hex) begin
          bytes[n] = {hex_nibble(held_digit), hex_nibble(c)};
          n        = n + 2'd1;
        end else begin
          bytes[n] = CH_PERCENT;
          n        = n + 2'd1;
          bytes[n] = held_digit;
          n        = n + 2'd1;
          tail     = 1'b1;
        end
      end
      default: begin
        tail = 1'b1;
      end
    endcase

    // byte handled with nothing held
    if (tail) begin
      if (c == CH_PERCENT) begin
        phase_next = PH_PCT;
      end else begin
        bytes[n] = c;
        n        = n + 2'd1;
      end
    end

    // end of text flush
    if (in_last) begin
      if (phase_next == PH_PCT) begin
        bytes[n] = CH_PERCENT;
        n        = n + 2'd1;
      end else if (phase_next == PH_DIGIT) begin
        bytes[n] = CH_PERCENT;
        n        = n + 2'd1;
        bytes[n] = held_digit_next;
        n        = n + 2'd1;
      end
      phase_next      = PH_IDLE;
      held_digit_next = 8'h00;
    end
  end

  assign grp_valid = accept && (n != 2'd0);
  assign grp.b0    = bytes[0];
  assign grp.b1    = bytes[1];
  assign grp.b2    = bytes[2];
  assign grp.cnt   = n;
  assign grp.last  = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= 8'h00;
    end else if (accept) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

### rtl/core/pedec_queue.sv
// ----------------------------------------------------------------------------
// pedec_queue
// short first-word-fall-through queue of byte groups between front and back
// ----------------------------------------------------------------------------
module pedec_queue import pedec_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  group_t wdata,
  input  logic   rd,
  output group_t rdata,
  output logic   full,
  output logic   nonempty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  group_t        mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  logic do_wr, do_rd;

  assign full     = (count == FULL_CNT);
  assign nonempty = (count != '0);
  assign do_wr    = wr && !full;
  assign do_rd    = rd && nonempty;
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/core/pedec_back.sv
// ----------------------------------------------------------------------------
// pedec_back
// takes byte groups from the queue, hands out one item per cycle while popped
// ----------------------------------------------------------------------------
module pedec_back import pedec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_nonempty,
  input  group_t     q_data,
  output logic       q_rd,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_last
);

  group_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       ovalid;

  logic       out_ready;
  logic       cur_end;
  logic       cur_done;
  logic [7:0] cur_byte;

  assign out_ready = !ovalid || pop;
  assign cur_end   = (idx == (cur.cnt - 2'd1));
  assign cur_done  = cur_valid && out_ready && cur_end;
  assign q_rd      = q_nonempty && (!cur_valid || cur_done);
  assign empty     = !ovalid;

  always_comb begin
    case (idx)
      2'd0:    cur_byte = cur.b0;
      2'd1:    cur_byte = cur.b1;
      default: cur_byte = cur.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
    if (cur_valid && out_ready) begin
      out_byte <= cur_byte;
      out_last <= cur.last && cur_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      ovalid    <= 1'b0;
    end else begin
      if (out_ready) begin
        ovalid <= cur_valid;
      end
      if (q_rd) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else if (cur_valid && out_ready) begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

### rtl/core/percent_escape_decoder_top.sv
// ----------------------------------------------------------------------------
// percent_escape_decoder_top
// streaming form-urlencoded decoder: plus to space, percent escapes to bytes
// ----------------------------------------------------------------------------
// path: an accepted item's group passes the queue and the back end's current
//   group to the registered result ports; held bytes appear with the item
//   that frees them. throughput: one item per cycle unless full; results leave
//   one per cycle while popped, and a two or three byte group holds the back end
// reset: synchronous, clears escape phase, held digit, queue and output stage
module percent_escape_decoder_top import pedec_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic   accept;
  logic   grp_valid;
  group_t grp;
  group_t q_data;
  logic   q_rd;
  logic   q_nonempty;

  assign accept = push && !full;

  pedec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  pedec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (grp_valid),
    .wdata    (grp),
    .rd       (q_rd),
    .rdata    (q_data),
    .full     (full),
    .nonempty (q_nonempty)
  );

  pedec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_data     (q_data),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule
